/* hdl/apq_pkg.sv */
// ----------------------------------------------------------------------------
// apq_pkg: shared types and codes for the array min priority queue
// Transfer structs, operation kinds, vertex status and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

  localparam int MAX_VERTICES_DEF  = 256;
  localparam int PRIORITY_BITS_DEF = 32;
  localparam int VERTEX_W          = 9;
  localparam int PRIO_REQ_W        = 32;
  localparam int KIND_W            = 3;

  localparam logic [VERTEX_W-1:0] NUM_VERTICES_RST = 9'd256;

  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DECREASE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE_MIN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET_MIN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

  localparam logic [1:0] ST_UNSEEN = 2'd0;
  localparam logic [1:0] ST_FRINGE = 2'd1;
  localparam logic [1:0] ST_INTREE = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [VERTEX_W-1:0]   vertex;
    logic [PRIO_REQ_W-1:0] priority_req;
    logic [VERTEX_W-1:0]   parent_vertex;
  } apq_in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]   min_vertex;
    logic [1:0]            entry_status;
    logic [VERTEX_W-1:0]   entry_parent;
    logic [PRIO_REQ_W-1:0] entry_priority;
    logic                  is_empty;
    logic [1:0]            error;
  } apq_out_t;

  typedef struct packed {
    logic rd_en;
    logic st_we;
    logic dt_we;
  } apq_mem_ctl_t;

  typedef struct packed {
    logic start;
    logic issue;
  } apq_scan_ctl_t;

endpackage

`default_nettype wire

/* hdl/apq_store.sv */
// ----------------------------------------------------------------------------
// apq_store: per-vertex storage
// Status memory and parent/priority memory, one write and one registered
// read per cycle, shared address per direction.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_store import apq_pkg::*; #(
  parameter int DEPTH = MAX_VERTICES_DEF,
  parameter int PW    = PRIORITY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire apq_mem_ctl_t             ctl,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [1:0]               st_wdata,
  input  wire logic [VERTEX_W-1:0]      par_wdata,
  input  wire logic [PW-1:0]            prio_wdata,
  output logic      [1:0]               st_rdata,
  output logic      [VERTEX_W-1:0]      par_rdata,
  output logic      [PW-1:0]            prio_rdata
);

  logic [1:0]                 st_mem [0:DEPTH-1];
  logic [VERTEX_W+PW-1:0]     dt_mem [0:DEPTH-1];
  logic [1:0]                 st_rd_r;
  logic [VERTEX_W+PW-1:0]     dt_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.st_we) begin
      st_mem[wr_addr] <= st_wdata;
    end
    if (ctl.dt_we) begin
      dt_mem[wr_addr] <= {par_wdata, prio_wdata};
    end
    if (ctl.rd_en) begin
      st_rd_r <= st_mem[rd_addr];
      dt_rd_r <= dt_mem[rd_addr];
    end
  end

  assign st_rdata   = st_rd_r;
  assign par_rdata  = dt_rd_r[VERTEX_W+PW-1:PW];
  assign prio_rdata = dt_rd_r[PW-1:0];

endmodule

`default_nettype wire

/* hdl/apq_min_scan.sv */
// ----------------------------------------------------------------------------
// apq_min_scan: running minimum over the vertex sweep
// Tags each read issued to the store and keeps the lowest-numbered fringe
// vertex with the strictly smallest finite priority.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_min_scan import apq_pkg::*; #(
  parameter int PW = PRIORITY_BITS_DEF,
  parameter int VW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire apq_scan_ctl_t ctl,
  input  wire logic [VW-1:0] issue_vtx,
  input  wire logic [1:0]    smp_status,
  input  wire logic [PW-1:0] smp_prio,
  output logic      [VW-1:0] best_vtx
);

  logic          tag_vld_r;
  logic [VW-1:0] tag_vtx_r;
  logic [VW-1:0] best_vtx_r;
  logic [PW-1:0] best_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= ctl.issue;
    end
    tag_vtx_r <= issue_vtx;
    if (ctl.start) begin
      best_vtx_r <= '0;
      best_p_r   <= '1;
    end else if (tag_vld_r && smp_status == ST_FRINGE && smp_prio < best_p_r) begin
      best_vtx_r <= tag_vtx_r;
      best_p_r   <= smp_prio;
    end
  end

  assign best_vtx = best_vtx_r;

endmodule

`default_nettype wire

/* hdl/array_min_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// array_min_priority_queue_top: vertex-indexed min priority queue
// Insert, decrease key, delete min, get min and read entry over per-vertex
// status, parent and priority held in block memories, with a cached minimum.
//
//   channel  ports                          payload
//   in       in_valid / in_ready            in_data  (apq_in_t)
//   out      out_valid / out_ready          out_data (apq_out_t)
//   cfg      cfg_we                         cfg_wdata (num_vertices)
//
// Insert, decrease, read and cached get/delete step through IDLE, EXEC, RESP.
// Uncached get/delete sweeps the store (SCAN, DRAIN, FIN), one vertex read per cycle.
// After reset a clearing pass over all MAX_VERTICES entries sets status to
// unseen; in_ready stays low meanwhile.
// One item in flight; a held result stalls only the next item's completion.
// ----------------------------------------------------------------------------
`default_nettype none

module array_min_priority_queue_top import apq_pkg::*; #(
  parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire apq_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output apq_out_t                 out_data,
  input  wire logic                cfg_we,
  input  wire logic [VERTEX_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (VW > VERTEX_W) ? VW : VERTEX_W;
  localparam int PW = PRIORITY_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SCAN, S_DRAIN, S_FIN, S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  apq_in_t               item_r, item_nxt;
  logic [VW-1:0]         cnt_r, cnt_nxt;
  logic [VERTEX_W-1:0]   cmin_r, cmin_nxt;
  logic                  cvld_r, cvld_nxt;
  logic [VERTEX_W-1:0]   nv_r;
  apq_out_t              res_r, res_nxt;
  logic                  oval_r, oval_nxt;
  apq_out_t              odata_r, odata_nxt;

  apq_mem_ctl_t          mctl;
  apq_scan_ctl_t         sctl;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [1:0]            st_wdata;
  logic [1:0]            st_rd;
  logic [VERTEX_W-1:0]   par_rd;
  logic [PW-1:0]         prio_rd;
  logic [VW-1:0]         best_vtx;

  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         item_vx;
  logic                  in_range;
  logic                  needs_v;
  logic                  fin;
  logic [VERTEX_W-1:0]   m_sel;

  always_comb begin
    if (nv_r == '0) begin
      n_eff = CW'(1);
    end else if (CW'(nv_r) > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(nv_r);
    end
  end

  assign item_vx  = CW'(item_r.vertex);
  assign in_range = (item_vx != '0) && (item_vx <= n_eff);
  assign needs_v  = (item_r.kind == KIND_INSERT) || (item_r.kind == KIND_DECREASE) ||
                    (item_r.kind == KIND_READ);
  assign m_sel    = (state_r == S_FIN) ? VERTEX_W'(best_vtx) : cmin_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    cmin_nxt  = cmin_r;
    cvld_nxt  = cvld_r;
    res_nxt   = res_r;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;
    mctl      = '0;
    sctl      = '0;
    rd_addr   = idx_r;
    wr_addr   = idx_r;
    st_wdata  = ST_UNSEEN;
    fin       = 1'b0;

    if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mctl.st_we = 1'b1;
        idx_nxt    = idx_r + AW'(1);
        if (idx_r == AW'(MAX_VERTICES - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          mctl.rd_en = 1'b1;
          rd_addr    = AW'(in_data.vertex - VERTEX_W'(1));
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_RESP;
        wr_addr   = AW'(item_r.vertex - VERTEX_W'(1));
        if (needs_v && !in_range) begin
          res_nxt.error = ERR_RANGE;
        end else begin
          unique case (item_r.kind)
            KIND_INSERT: begin
              mctl.dt_we = 1'b1;
              mctl.st_we = 1'b1;
              st_wdata   = ST_FRINGE;
              if (st_rd != ST_FRINGE) begin
                cnt_nxt = cnt_r + VW'(1);
              end
              cvld_nxt = 1'b0;
            end
            KIND_DECREASE: begin
              mctl.dt_we = 1'b1;
              cvld_nxt   = 1'b0;
            end
            KIND_READ: begin
              res_nxt.entry_status   = st_rd;
              res_nxt.entry_parent   = par_rd;
              res_nxt.entry_priority = PRIO_REQ_W'(prio_rd);
            end
            KIND_DELETE_MIN, KIND_GET_MIN: begin
              if (item_r.kind == KIND_DELETE_MIN && cnt_r == '0) begin
                res_nxt.error = ERR_EMPTY;
              end else if (cvld_r) begin
                fin = 1'b1;
              end else begin
                sctl.start = 1'b1;
                idx_nxt    = '0;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        mctl.rd_en = 1'b1;
        sctl.issue = 1'b1;
        idx_nxt    = idx_r + AW'(1);
        if (CW'(idx_r) == n_eff - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_nxt  = '0;
        fin      = 1'b1;
        cmin_nxt = VERTEX_W'(best_vtx);
        cvld_nxt = 1'b1;
      end
      S_RESP: begin
        if (!oval_r || out_ready) begin
          oval_nxt  = 1'b1;
          odata_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_RESP;
      if (item_r.kind == KIND_GET_MIN) begin
        res_nxt.min_vertex = m_sel;
      end else if (m_sel == '0) begin
        res_nxt.error = ERR_EMPTY;
      end else begin
        mctl.st_we         = 1'b1;
        wr_addr            = AW'(m_sel - VERTEX_W'(1));
        st_wdata           = ST_INTREE;
        cnt_nxt            = cnt_r - VW'(1);
        cvld_nxt           = 1'b0;
        res_nxt.min_vertex = m_sel;
      end
    end

    if (state_r == S_EXEC || state_r == S_FIN) begin
      res_nxt.is_empty = (cnt_nxt == '0);
    end

    if (cfg_we) begin
      cvld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      cnt_r   <= '0;
      cmin_r  <= '0;
      cvld_r  <= 1'b0;
      nv_r    <= NUM_VERTICES_RST;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      cmin_r  <= cmin_nxt;
      cvld_r  <= cvld_nxt;
      oval_r  <= oval_nxt;
      if (cfg_we) begin
        nv_r <= cfg_wdata;
      end
    end
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = oval_r;
  assign out_data  = odata_r;

  apq_store #(
    .DEPTH (MAX_VERTICES),
    .PW    (PW)
  ) u_store (
    .clk        (clk),
    .ctl        (mctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .st_wdata   (st_wdata),
    .par_wdata  (item_r.parent_vertex),
    .prio_wdata (PW'(item_r.priority_req)),
    .st_rdata   (st_rd),
    .par_rdata  (par_rd),
    .prio_rdata (prio_rd)
  );

  apq_min_scan #(
    .PW (PW),
    .VW (VW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sctl),
    .issue_vtx  (VW'(idx_r) + VW'(1)),
    .smp_status (st_rd),
    .smp_prio   (prio_rd),
    .best_vtx   (best_vtx)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while an item is in flight");

  a_cache_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cvld_r |-> CW'(cmin_r) <= n_eff)
    else $error("cached minimum beyond active vertex count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CW'(idx_r) < n_eff)
    else $error("sweep index past active vertex count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= VW'(MAX_VERTICES))
    else $error("fringe count exceeds vertex capacity");

endmodule

`default_nettype wire
